// ===== src/scanline_irq_counter_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Scanline IRQ counter assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SCANLINE_IRQ_COUNTER_UNIT_DEFINES_SVH
`define SCANLINE_IRQ_COUNTER_UNIT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define SICU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SICU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sicu_pkg.sv =====
// ---------------------------------------------------------------------------
// Scanline IRQ counter package
// Request, response and state types, event codes and frame constants.
// ---------------------------------------------------------------------------
package sicu_pkg;

  localparam logic [7:0] LINES_PER_FRAME = 8'd241;

  typedef enum logic [2:0] {
    KIND_TICK       = 3'd0,
    KIND_RENDER_OFF = 3'd1,
    KIND_STATUS     = 3'd2,
    KIND_COMPARE    = 3'd3,
    KIND_ENABLE     = 3'd4,
    KIND_FRAME      = 3'd5
  } sicu_kind_t;

  typedef struct packed {
    sicu_kind_t  kind;
    logic        rendering;
    logic [7:0]  write_data;
  } sicu_req_t;

  typedef struct packed {
    logic               irq;
    logic [7:0]         read_data;
    logic signed [8:0]  line_counter;
  } sicu_rsp_t;

  typedef struct packed {
    logic [7:0]  line_count;
    logic [7:0]  render_base;
    logic        render_cut;
    logic        mid_frame;
    logic        pending;
    logic        fired;
    logic [7:0]  compare_value;
    logic        enable;
  } sicu_state_t;

endpackage

// ===== src/sicu_step.sv =====
// ---------------------------------------------------------------------------
// Scanline IRQ counter step
// Next state and response for one request, from the current state.
// ---------------------------------------------------------------------------
module sicu_step
  import sicu_pkg::*;
(
  input  sicu_state_t st,
  input  sicu_req_t   req,
  output sicu_state_t st_next,
  output sicu_rsp_t   rsp
);

  logic       wrap;
  logic [7:0] k;
  logic [7:0] k_inc;
  logic [7:0] base_f;
  logic       off_f;
  logic [7:0] base_eff;
  logic       off_eff;
  logic       pend_eff;
  logic       fired_eff;
  logic [9:0] diff;
  logic       hit;
  logic       pend_new;
  logic       fire;

  // Start a new frame ahead of a tick once the frame is complete.
  assign wrap      = (st.line_count >= LINES_PER_FRAME);
  assign k         = wrap ? 8'd0 : st.line_count;
  assign k_inc     = k + 8'd1;
  assign base_f    = wrap ? 8'd0 : st.render_base;
  assign off_f     = wrap ? 1'b0 : st.render_cut;
  assign base_eff  = (k == 8'd0) ? 8'd0 : base_f;
  assign off_eff   = (k == 8'd0) ? 1'b0 : off_f;
  assign pend_eff  = (k == 8'd1) ? 1'b0 : st.pending;
  assign fired_eff = (k == 8'd1) ? 1'b0 : st.fired;
  assign diff      = {2'b00, k} - {2'b00, base_eff} - 10'd1;
  assign hit       = (st.compare_value != 8'd0) && (diff == {2'b00, st.compare_value});
  assign pend_new  = pend_eff | hit;
  assign fire      = pend_new && st.enable && !fired_eff;

  always_comb begin
    st_next = st;
    rsp     = '0;
    unique case (req.kind)
      KIND_TICK: begin
        st_next.line_count = k_inc;
        if (!req.rendering) begin
          st_next.mid_frame   = 1'b0;
          st_next.render_base = k_inc;
          st_next.render_cut  = (k != 8'd0) | off_f;
        end else begin
          st_next.render_base = base_eff;
          st_next.render_cut  = off_eff;
          st_next.pending     = pend_new;
          st_next.fired       = fired_eff | fire;
          st_next.mid_frame   = (k >= 8'd2) && !off_eff;
          rsp.irq             = fire;
          rsp.line_counter    = signed'(diff[8:0]);
        end
      end
      KIND_RENDER_OFF: begin
        st_next.mid_frame   = 1'b0;
        st_next.render_base = st.line_count;
        st_next.render_cut  = st.render_cut |
          ((st.line_count != 8'd0) && (st.line_count < LINES_PER_FRAME));
      end
      KIND_STATUS: begin
        rsp.read_data   = {st.pending, st.mid_frame, 6'b000000};
        st_next.pending = 1'b0;
        st_next.fired   = 1'b0;
      end
      KIND_COMPARE: begin
        st_next.compare_value = req.write_data;
      end
      KIND_ENABLE: begin
        st_next.enable = req.write_data[7];
      end
      KIND_FRAME: begin
        st_next.line_count  = 8'd0;
        st_next.mid_frame   = 1'b0;
        st_next.render_base = 8'd0;
        st_next.render_cut  = 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/scanline_irq_counter_unit.sv =====
// ---------------------------------------------------------------------------
// Scanline IRQ counter unit
// Input register, state update and result register of the scanline counter.
// ---------------------------------------------------------------------------
// Takes one request per clock while the response side does not stall and
// returns exactly one response per request, each held first in the input
// register and then in the result register. The state loop (line count,
// base, flags, compare and enable) closes through sicu_step, so requests
// follow each other back to back.
`include "scanline_irq_counter_unit_defines.svh"

module scanline_irq_counter_unit
  import sicu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  sicu_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output sicu_rsp_t rsp
);

  logic        s1_valid;
  sicu_req_t   s1_req;
  logic        advance;
  sicu_state_t st;
  sicu_state_t st_next;
  sicu_rsp_t   step_rsp;

  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || advance;

  sicu_step u_step (
    .st      (st),
    .req     (s1_req),
    .st_next (st_next),
    .rsp     (step_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s1_req <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      rsp <= step_rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance && s1_valid) begin
      st <= st_next;
    end
  end

  `SICU_ASSERT_NEXT(a_irq_sets_fired, advance && s1_valid && step_rsp.irq, st.fired, "irq without fired")
  `SICU_ASSERT_NOW(a_irq_needs_enable, advance && s1_valid && step_rsp.irq, st.enable, "irq while disabled")
  `SICU_ASSERT_NOW(a_count_bound, 1'b1, st.line_count <= LINES_PER_FRAME, "line count overrun")
  `SICU_ASSERT_NOW(a_mid_frame_cut, st.mid_frame, !st.render_cut, "in frame after render off")

endmodule

// ===== tb/scanline_irq_counter_unit_checker.sv =====
// ---------------------------------------------------------------------------
// Scanline IRQ counter checker
// Watches both channels and predicts each response from the accepted requests.
// It compares every response field by field against the oldest prediction
// and counts mismatches and responses that arrive with no prediction queued.
// ---------------------------------------------------------------------------
module scanline_irq_counter_unit_checker
  import sicu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_ready,
  input  sicu_req_t req,
  input  logic      rsp_valid,
  input  logic      rsp_ready,
  input  sicu_rsp_t rsp,
  output int        mismatches,
  output int        awaited
);

  sicu_state_t counter_state;
  sicu_rsp_t   predicted_rsps[$];

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic void restart_frame();
    counter_state.line_count  = '0;
    counter_state.mid_frame   = 1'b0;
    counter_state.render_base = '0;
    counter_state.render_cut  = 1'b0;
  endfunction

  function automatic sicu_rsp_t advance_counter(input sicu_req_t r);
    sicu_rsp_t  o;
    logic [7:0] k;
    int         ctr;
    o = '0;
    case (r.kind)
      KIND_TICK: begin
        if (counter_state.line_count >= LINES_PER_FRAME) restart_frame();
        k = counter_state.line_count;
        counter_state.line_count = k + 8'd1;
        if (!r.rendering) begin
          counter_state.mid_frame   = 1'b0;
          counter_state.render_base = counter_state.line_count;
          if (k != 8'd0) counter_state.render_cut = 1'b1;
        end else begin
          if (k == 8'd0) begin
            counter_state.render_base = '0;
            counter_state.render_cut  = 1'b0;
            counter_state.mid_frame   = 1'b0;
          end
          ctr = int'(k) - int'(counter_state.render_base) - 1;
          o.line_counter = ctr[8:0];
          if (k == 8'd1) begin
            counter_state.pending = 1'b0;
            counter_state.fired   = 1'b0;
          end
          counter_state.mid_frame = (k >= 8'd2) && !counter_state.render_cut;
          if (counter_state.compare_value != 8'd0 &&
              ctr == int'(counter_state.compare_value))
            counter_state.pending = 1'b1;
          if (counter_state.pending && counter_state.enable && !counter_state.fired) begin
            counter_state.fired = 1'b1;
            o.irq = 1'b1;
          end
        end
      end
      KIND_RENDER_OFF: begin
        counter_state.mid_frame   = 1'b0;
        counter_state.render_base = counter_state.line_count;
        if (counter_state.line_count != 8'd0 &&
            counter_state.line_count < LINES_PER_FRAME)
          counter_state.render_cut = 1'b1;
      end
      KIND_STATUS: begin
        o.read_data = {counter_state.pending, counter_state.mid_frame, 6'b0};
        counter_state.pending = 1'b0;
        counter_state.fired   = 1'b0;
      end
      KIND_COMPARE: counter_state.compare_value = r.write_data;
      KIND_ENABLE:  counter_state.enable = r.write_data[7];
      KIND_FRAME:   restart_frame();
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin : watch
    sicu_rsp_t want;
    if (rst) begin
      counter_state = '0;
      predicted_rsps.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (predicted_rsps.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = predicted_rsps.pop_front();
          if (rsp.irq !== want.irq)
            report_mismatch($sformatf("irq %b, expected %b", rsp.irq, want.irq));
          if (rsp.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %h, expected %h",
                                      rsp.read_data, want.read_data));
          if (rsp.line_counter !== want.line_counter)
            report_mismatch($sformatf("line_counter %0d, expected %0d",
                                      rsp.line_counter, want.line_counter));
        end
      end
      if (req_valid && req_ready) predicted_rsps.push_back(advance_counter(req));
    end
    awaited = predicted_rsps.size();
  end

endmodule

// ===== tb/scanline_irq_counter_unit_tb.sv =====
// ---------------------------------------------------------------------------
// Scanline IRQ counter testbench
// Drives directed and random event requests into the counter unit with random
// gaps and response stalls, including a long response hold-off, and reports
// the verdict from the checker's mismatch count.
// ---------------------------------------------------------------------------
module scanline_irq_counter_unit_tb
  import sicu_pkg::*;
();

  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  sicu_req_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  sicu_rsp_t rsp;
  int        fail_count;
  int        rsps_awaited;
  bit        sender_idles;

  scanline_irq_counter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  scanline_irq_counter_unit_checker counter_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .mismatches (fail_count),
    .awaited    (rsps_awaited)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #4000000;
    $display("[scanline_irq_counter_unit] ERROR");
    $finish;
  end

  initial begin : receiver
    int cyc;
    cyc = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= 300 && cyc < 360) rsp_ready = 1'b0;
      else if (cyc >= 700 && cyc < 1000) rsp_ready = 1'b1;
      else rsp_ready = $urandom_range(0, 99) >= 38;
    end
  end

  function automatic logic [7:0] compare_byte();
    return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 30)) : 8'($urandom);
  endfunction

  task automatic send_request(input sicu_kind_t kind, input logic rendering,
                              input logic [7:0] data);
    while (sender_idles && $urandom_range(0, 99) < 38) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req.kind       = kind;
    req.rendering  = rendering;
    req.write_data = data;
    req_valid      = 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic send_side_event();
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 0) send_request(KIND_STATUS, 1'($urandom), 8'($urandom));
    else if (pick == 1) send_request(KIND_COMPARE, 1'($urandom), compare_byte());
    else send_request(KIND_ENABLE, 1'($urandom),
                      {$urandom_range(0, 9) < 7, 7'($urandom)});
  endtask

  task automatic send_random_request();
    int w;
    w = $urandom_range(0, 99);
    if (w < 62) send_request(KIND_TICK, 1'b1, 8'($urandom));
    else if (w < 68) send_request(KIND_TICK, 1'b0, 8'($urandom));
    else if (w < 86) send_side_event();
    else if (w < 90) send_request(KIND_RENDER_OFF, 1'($urandom), 8'($urandom));
    else if (w < 96) send_request(KIND_FRAME, 1'($urandom), 8'($urandom));
    else if (w < 98) send_request(sicu_kind_t'(KIND_SPARE_LO), 1'($urandom), 8'($urandom));
    else send_request(sicu_kind_t'(KIND_SPARE_HI), 1'($urandom), 8'($urandom));
  endtask

  initial begin : stimulus
    int ticks;
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    sender_idles = 1'b1;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    send_request(KIND_COMPARE, 1'b0, 8'h00);
    send_request(KIND_TICK, 1'b1, 8'h00);
    send_request(KIND_TICK, 1'b1, 8'hFF);
    send_request(KIND_ENABLE, 1'b0, 8'hFF);
    send_request(KIND_COMPARE, 1'b1, 8'h02);
    send_request(KIND_TICK, 1'b1, 8'h00);
    send_request(KIND_TICK, 1'b1, 8'h00);
    send_request(KIND_TICK, 1'b1, 8'h00);
    send_request(KIND_STATUS, 1'b0, 8'h00);
    send_request(KIND_RENDER_OFF, 1'b0, 8'h00);
    send_request(KIND_TICK, 1'b1, 8'h00);
    send_request(KIND_TICK, 1'b1, 8'h00);
    send_request(KIND_TICK, 1'b1, 8'h00);
    send_request(KIND_TICK, 1'b1, 8'h00);
    send_request(KIND_STATUS, 1'b1, 8'hFF);
    send_request(KIND_TICK, 1'b0, 8'h00);
    send_request(KIND_ENABLE, 1'b1, 8'h7F);
    send_request(KIND_TICK, 1'b1, 8'h00);
    send_request(sicu_kind_t'(KIND_SPARE_LO), 1'b1, 8'hFF);
    send_request(sicu_kind_t'(KIND_SPARE_HI), 1'b0, 8'h00);
    send_request(KIND_FRAME, 1'b0, 8'h00);
    send_request(KIND_TICK, 1'b0, 8'h00);
    send_request(KIND_COMPARE, 1'b0, 8'hFF);
    send_request(KIND_TICK, 1'b1, 8'h00);
    send_request(KIND_STATUS, 1'b0, 8'h00);

    // run one full frame, then render off past its end and wrap
    send_request(KIND_FRAME, 1'($urandom), 8'($urandom));
    send_request(KIND_ENABLE, 1'($urandom), 8'h80);
    send_request(KIND_COMPARE, 1'($urandom), 8'($urandom_range(1, 240)));
    ticks = 0;
    while (ticks < 241) begin
      if ($urandom_range(0, 99) < 8) begin
        send_side_event();
      end else begin
        send_request(KIND_TICK, 1'b1, 8'($urandom));
        ticks++;
      end
    end
    send_request(KIND_RENDER_OFF, 1'($urandom), 8'($urandom));
    send_request(KIND_STATUS, 1'($urandom), 8'($urandom));
    send_request(KIND_TICK, 1'b1, 8'($urandom));

    for (int i = 0; i < 390; i++) begin
      sender_idles = !(i >= 100 && i < 180);
      send_random_request();
    end
    sender_idles = 1'b1;
    req_valid = 1'b0;

    while (rsps_awaited != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) $display("[scanline_irq_counter_unit] OK");
    else $display("[scanline_irq_counter_unit] ERROR");
    $finish;
  end

endmodule
